[rtl/core/ipag_pkg.sv]
// Package with the item types and postbyte mode codes of the indexed address generator.
`timescale 1ns / 1ps

package ipag_pkg;

    // One input item: postbyte, the two following bytes and the CPU register view.
    typedef struct packed {
        logic [7:0]  postbyte;
        logic [7:0]  offset_first;
        logic [7:0]  offset_second;
        logic [15:0] reg_x;
        logic [15:0] reg_y;
        logic [15:0] reg_u;
        logic [15:0] reg_s;
        logic [7:0]  acc_a;
        logic [7:0]  acc_b;
        logic [15:0] pc_after_post;
    } t_req;

    // One result item.
    typedef struct packed {
        logic [15:0] address;
        logic        indirect;
        logic        reg_write;
        logic [1:0]  reg_select;
        logic [15:0] reg_value;
        logic [1:0]  offset_bytes;
        logic [3:0]  extra_cycles;
        logic        bad_postbyte;
    } t_rsp;

    // Register select codes in postbyte bits 6:5.
    localparam logic [1:0] REG_X = 2'd0;
    localparam logic [1:0] REG_Y = 2'd1;
    localparam logic [1:0] REG_U = 2'd2;
    localparam logic [1:0] REG_S = 2'd3;

    // Postbyte bit 7 set selects the mode field; otherwise bits 4:0 hold a 5-bit offset.
    localparam int unsigned PB_MODE_BIT = 7;

    // Mode codes in postbyte bits 4:0; the indirect flag is bit 4.
    localparam logic [4:0] MODE_IND       = 5'h10;
    localparam logic [4:0] MODE_POST_INC1 = 5'h00;
    localparam logic [4:0] MODE_POST_INC2 = 5'h01;
    localparam logic [4:0] MODE_PRE_DEC1  = 5'h02;
    localparam logic [4:0] MODE_PRE_DEC2  = 5'h03;
    localparam logic [4:0] MODE_ZERO      = 5'h04;
    localparam logic [4:0] MODE_ACC_B     = 5'h05;
    localparam logic [4:0] MODE_ACC_A     = 5'h06;
    localparam logic [4:0] MODE_OFF8      = 5'h08;
    localparam logic [4:0] MODE_OFF16     = 5'h09;
    localparam logic [4:0] MODE_ACC_D     = 5'h0B;
    localparam logic [4:0] MODE_PCR8      = 5'h0C;
    localparam logic [4:0] MODE_PCR16     = 5'h0D;
    localparam logic [4:0] MODE_EXT_IND   = 5'h1F;

    // Cycles that indirection adds on top of the base form.
    localparam logic [3:0] IND_CYCLES = 4'd3;

endpackage

[rtl/core/ipag_chan_if.sv]
// Valid/ready channel interface carrying one item of a chosen payload type.
`timescale 1ns / 1ps

interface ipag_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/indexed_postbyte_address_gen.sv]
// Top level of the indexed-mode postbyte decoder and effective address generator.
// Three register stages (decode and operand selection, one 16-bit add, result composition)
// carry an accepted item to o_rsp. Throughput is one item per cycle while o_rsp is ready,
// set by these stages, each of which hands on an item per cycle.
// Reset (synchronous, active low) clears the stage valid bits; no result is pending after it.
// A stalled output holds its stage; earlier stages keep filling any empty slot behind it.
`timescale 1ns / 1ps

module indexed_postbyte_address_gen (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ipag_chan_if.sink    i_req,
    ipag_chan_if.source  o_rsp
);

    // Per-item control that travels down the pipe next to the datapath.
    typedef struct packed {
        logic [1:0] sel;     // register picked by the postbyte
        logic       wr;      // auto increment or decrement writes the register back
        logic       post;    // address is the unmodified base (post increment)
        logic       ind;     // indirect form
        logic       bad;     // undefined postbyte
        logic [1:0] nbytes;  // offset bytes consumed
        logic [3:0] cyc;     // extra cycles, indirection included
    } t_meta;

    typedef struct packed {
        logic [15:0] base;
        logic [15:0] off;
        t_meta       meta;
    } t_s1;

    typedef struct packed {
        logic [15:0] base;
        logic [15:0] sum;
        t_meta       meta;
    } t_s2;

    // Stage valid bits and payload registers.
    logic r_v1, r_v2, r_v3;
    t_s1  r_s1, n_s1;
    t_s2  r_s2, n_s2;
    ipag_pkg::t_rsp r_out, n_out;

    // Each stage advances when it is empty or when the stage after it advances.
    // This lets a bubble close up while a finished result waits at the output.
    logic w_en1, w_en2, w_en3;

    assign w_en3 = !r_v3 || o_rsp.ready;
    assign w_en2 = !r_v2 || w_en3;
    assign w_en1 = !r_v1 || w_en2;

    assign i_req.ready = w_en1;
    assign o_rsp.valid = r_v3;
    assign o_rsp.data  = r_out;

    // Stage 1: decode the postbyte, pick the base register and build the addend.
    // PC-relative forms take the PC after the offset bytes as base, so the PC
    // increment happens here and stage 2 needs only one add.
    logic [7:0]  w_pb;
    logic [15:0] w_reg;
    logic [15:0] w_w16;
    logic [15:0] w_sext_a, w_sext_b, w_sext_b1, w_sext5;

    assign w_pb      = i_req.data.postbyte;
    assign w_w16     = {i_req.data.offset_first, i_req.data.offset_second};
    assign w_sext_a  = {{8{i_req.data.acc_a[7]}}, i_req.data.acc_a};
    assign w_sext_b  = {{8{i_req.data.acc_b[7]}}, i_req.data.acc_b};
    assign w_sext_b1 = {{8{i_req.data.offset_first[7]}}, i_req.data.offset_first};
    assign w_sext5   = {{11{w_pb[4]}}, w_pb[4:0]};

    always_comb begin
        case (w_pb[6:5])
            ipag_pkg::REG_X: w_reg = i_req.data.reg_x;
            ipag_pkg::REG_Y: w_reg = i_req.data.reg_y;
            ipag_pkg::REG_U: w_reg = i_req.data.reg_u;
            ipag_pkg::REG_S: w_reg = i_req.data.reg_s;
            default:         w_reg = i_req.data.reg_x;
        endcase
    end

    always_comb begin
        n_s1             = '0;
        n_s1.base        = w_reg;
        n_s1.meta.sel    = w_pb[6:5];
        if (!w_pb[ipag_pkg::PB_MODE_BIT]) begin
            n_s1.off      = w_sext5;
            n_s1.meta.cyc = 4'd1;
        end else begin
            case (w_pb[4:0])
                ipag_pkg::MODE_POST_INC1: begin
                    n_s1.off       = 16'h0001;
                    n_s1.meta.wr   = 1'b1;
                    n_s1.meta.post = 1'b1;
                    n_s1.meta.cyc  = 4'd2;
                end
                ipag_pkg::MODE_POST_INC2,
                ipag_pkg::MODE_POST_INC2 | ipag_pkg::MODE_IND: begin
                    n_s1.off       = 16'h0002;
                    n_s1.meta.wr   = 1'b1;
                    n_s1.meta.post = 1'b1;
                    n_s1.meta.cyc  = 4'd3;
                end
                ipag_pkg::MODE_PRE_DEC1: begin
                    n_s1.off      = 16'hFFFF;
                    n_s1.meta.wr  = 1'b1;
                    n_s1.meta.cyc = 4'd2;
                end
                ipag_pkg::MODE_PRE_DEC2,
                ipag_pkg::MODE_PRE_DEC2 | ipag_pkg::MODE_IND: begin
                    n_s1.off      = 16'hFFFE;
                    n_s1.meta.wr  = 1'b1;
                    n_s1.meta.cyc = 4'd3;
                end
                ipag_pkg::MODE_ZERO,
                ipag_pkg::MODE_ZERO | ipag_pkg::MODE_IND: begin
                    n_s1.off      = 16'h0000;
                    n_s1.meta.cyc = 4'd0;
                end
                ipag_pkg::MODE_ACC_B,
                ipag_pkg::MODE_ACC_B | ipag_pkg::MODE_IND: begin
                    n_s1.off      = w_sext_b;
                    n_s1.meta.cyc = 4'd1;
                end
                ipag_pkg::MODE_ACC_A,
                ipag_pkg::MODE_ACC_A | ipag_pkg::MODE_IND: begin
                    n_s1.off      = w_sext_a;
                    n_s1.meta.cyc = 4'd1;
                end
                ipag_pkg::MODE_OFF8,
                ipag_pkg::MODE_OFF8 | ipag_pkg::MODE_IND: begin
                    n_s1.off         = w_sext_b1;
                    n_s1.meta.nbytes = 2'd1;
                    n_s1.meta.cyc    = 4'd1;
                end
                ipag_pkg::MODE_OFF16,
                ipag_pkg::MODE_OFF16 | ipag_pkg::MODE_IND: begin
                    n_s1.off         = w_w16;
                    n_s1.meta.nbytes = 2'd2;
                    n_s1.meta.cyc    = 4'd4;
                end
                ipag_pkg::MODE_ACC_D,
                ipag_pkg::MODE_ACC_D | ipag_pkg::MODE_IND: begin
                    n_s1.off      = {i_req.data.acc_a, i_req.data.acc_b};
                    n_s1.meta.cyc = 4'd4;
                end
                ipag_pkg::MODE_PCR8,
                ipag_pkg::MODE_PCR8 | ipag_pkg::MODE_IND: begin
                    n_s1.base        = i_req.data.pc_after_post + 16'd1;
                    n_s1.off         = w_sext_b1;
                    n_s1.meta.nbytes = 2'd1;
                    n_s1.meta.cyc    = 4'd1;
                end
                ipag_pkg::MODE_PCR16,
                ipag_pkg::MODE_PCR16 | ipag_pkg::MODE_IND: begin
                    n_s1.base        = i_req.data.pc_after_post + 16'd2;
                    n_s1.off         = w_w16;
                    n_s1.meta.nbytes = 2'd2;
                    n_s1.meta.cyc    = 4'd5;
                end
                ipag_pkg::MODE_EXT_IND: begin
                    n_s1.base        = 16'h0000;
                    n_s1.off         = w_w16;
                    n_s1.meta.nbytes = 2'd2;
                    n_s1.meta.cyc    = 4'd2;
                end
                default: begin
                    // Undefined postbyte: everything in the result but the flag reads as zero.
                    n_s1.base     = 16'h0000;
                    n_s1.off      = 16'h0000;
                    n_s1.meta.bad = 1'b1;
                end
            endcase
            n_s1.meta.ind = w_pb[4] && !n_s1.meta.bad;
            if (n_s1.meta.ind) begin
                n_s1.meta.cyc = n_s1.meta.cyc + ipag_pkg::IND_CYCLES;
            end
        end
    end

    // Stage 2: the one 16-bit add. For auto increment and decrement the sum is
    // the new register value as well.
    always_comb begin
        n_s2.base = r_s1.base;
        n_s2.sum  = r_s1.base + r_s1.off;
        n_s2.meta = r_s1.meta;
    end

    // Stage 3: choose the address and zero the write-back fields when unused.
    always_comb begin
        n_out.address      = r_s2.meta.post ? r_s2.base : r_s2.sum;
        n_out.indirect     = r_s2.meta.ind;
        n_out.reg_write    = r_s2.meta.wr;
        n_out.reg_select   = r_s2.meta.wr ? r_s2.meta.sel : 2'd0;
        n_out.reg_value    = r_s2.meta.wr ? r_s2.sum : 16'h0000;
        n_out.offset_bytes = r_s2.meta.nbytes;
        n_out.extra_cycles = r_s2.meta.cyc;
        n_out.bad_postbyte = r_s2.meta.bad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_req.valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
            if (w_en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_s1 <= n_s1;
        end
        if (w_en2) begin
            r_s2 <= n_s2;
        end
        if (w_en3) begin
            r_out <= n_out;
        end
    end

endmodule

[rtl/core/ipag_checker.sv]
// Port-level checker for the indexed address generator and its bind statement.
`timescale 1ns / 1ps

module ipag_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_address,
    input logic        i_indirect,
    input logic        i_reg_write,
    input logic [1:0]  i_reg_select,
    input logic [15:0] i_reg_value,
    input logic [1:0]  i_offset_bytes,
    input logic [3:0]  i_extra_cycles,
    input logic        i_bad_postbyte
);

    // Reset empties the pipe, so no result is offered in the cycle after it.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result offered right after reset");

    // An undefined postbyte clears every other field of its result.
    a_bad_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_bad_postbyte) |->
        (i_address == 16'h0000 && !i_indirect && !i_reg_write &&
         i_offset_bytes == 2'd0 && i_extra_cycles == 4'd0))
        else $error("undefined postbyte result carries nonzero fields");

    // Without a write-back the register fields read as zero.
    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_reg_write) |->
        (i_reg_select == 2'd0 && i_reg_value == 16'h0000))
        else $error("register fields set without a write-back");

    // Indirection always costs its share, and no form exceeds the total of indirect PCR16.
    a_cycle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_extra_cycles <= 4'd8 &&
                         (!i_indirect || i_extra_cycles >= 4'd3)))
        else $error("extra cycle count out of range");

    // A result that is not taken stays put.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
        (i_out_valid && $stable(i_address) && $stable(i_reg_value) &&
         $stable(i_extra_cycles)))
        else $error("stalled result changed");

endmodule

bind indexed_postbyte_address_gen ipag_checker u_ipag_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_out_valid    (o_rsp.valid),
    .i_out_ready    (o_rsp.ready),
    .i_address      (o_rsp.data.address),
    .i_indirect     (o_rsp.data.indirect),
    .i_reg_write    (o_rsp.data.reg_write),
    .i_reg_select   (o_rsp.data.reg_select),
    .i_reg_value    (o_rsp.data.reg_value),
    .i_offset_bytes (o_rsp.data.offset_bytes),
    .i_extra_cycles (o_rsp.data.extra_cycles),
    .i_bad_postbyte (o_rsp.data.bad_postbyte)
);

[dv/tb.sv]
// Self-checking testbench for the indexed-mode postbyte decoder and address generator.
`timescale 1ns / 1ps

module tb;

    // Generous bound on the run: roughly 1700 items with random gaps on both sides
    // stay far below it even with the longest stalls.
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned RANDOM_ITEMS = 1650;
    // Output stages of the block; used for the drain wait at the end.
    localparam int unsigned PIPE_DEPTH = 3;

    // Directed postbytes: 5-bit offsets on every register, every mode with a mix
    // of direct and indirect forms, extended indirect, and every undefined mode code on X.
    localparam logic [7:0] DIRECTED_PB [26] = '{
        8'h00, 8'h2F, 8'h50, 8'h7F,
        8'h80, 8'hA1, 8'hC2, 8'hE3, 8'h84, 8'h95, 8'hA6, 8'hB8, 8'hC9, 8'hDB,
        8'h8C, 8'h9D, 8'h9F,
        8'h87, 8'h8A, 8'h8E, 8'h8F, 8'h90, 8'h92, 8'h97, 8'h9A, 8'h9E
    };

    // Scoreboard: predicts one result per accepted request and checks results in order.
    class t_ea_scoreboard;
        ipag_pkg::t_rsp expected_ea_q[$];
        int unsigned    errors;
        int unsigned    checked;
        int unsigned    bad_seen;
        int unsigned    writeback_seen;
        int unsigned    indirect_seen;

        function new();
            errors         = 0;
            checked        = 0;
            bad_seen       = 0;
            writeback_seen = 0;
            indirect_seen  = 0;
        endfunction

        // Decode a postbyte the way the CPU does and form the effective address.
        function ipag_pkg::t_rsp compute_effective_address(ipag_pkg::t_req r);
            ipag_pkg::t_rsp res;
            logic [1:0]     sel;
            logic [4:0]     mode;
            logic [15:0]    base;
            logic [15:0]    word;
            logic           bad;
            res  = '0;
            bad  = 1'b0;
            sel  = r.postbyte[6:5];
            mode = r.postbyte[4:0];
            word = {r.offset_first, r.offset_second};
            case (sel)
                ipag_pkg::REG_X: base = r.reg_x;
                ipag_pkg::REG_Y: base = r.reg_y;
                ipag_pkg::REG_U: base = r.reg_u;
                default:         base = r.reg_s;
            endcase
            if (!r.postbyte[ipag_pkg::PB_MODE_BIT]) begin
                // Short form: 5-bit signed offset in the postbyte itself.
                res.address      = base + {{11{mode[4]}}, mode};
                res.extra_cycles = 4'd1;
            end else begin
                res.indirect = (mode & ipag_pkg::MODE_IND) != '0;
                case (mode)
                    ipag_pkg::MODE_POST_INC1: begin
                        res.address      = base;
                        res.reg_write    = 1'b1;
                        res.reg_value    = base + 16'd1;
                        res.extra_cycles = 4'd2;
                    end
                    ipag_pkg::MODE_POST_INC2,
                    ipag_pkg::MODE_POST_INC2 | ipag_pkg::MODE_IND: begin
                        res.address      = base;
                        res.reg_write    = 1'b1;
                        res.reg_value    = base + 16'd2;
                        res.extra_cycles = 4'd3;
                    end
                    ipag_pkg::MODE_PRE_DEC1: begin
                        res.reg_value    = base - 16'd1;
                        res.address      = res.reg_value;
                        res.reg_write    = 1'b1;
                        res.extra_cycles = 4'd2;
                    end
                    ipag_pkg::MODE_PRE_DEC2,
                    ipag_pkg::MODE_PRE_DEC2 | ipag_pkg::MODE_IND: begin
                        res.reg_value    = base - 16'd2;
                        res.address      = res.reg_value;
                        res.reg_write    = 1'b1;
                        res.extra_cycles = 4'd3;
                    end
                    ipag_pkg::MODE_ZERO,
                    ipag_pkg::MODE_ZERO | ipag_pkg::MODE_IND: begin
                        res.address      = base;
                        res.extra_cycles = 4'd0;
                    end
                    ipag_pkg::MODE_ACC_B,
                    ipag_pkg::MODE_ACC_B | ipag_pkg::MODE_IND: begin
                        res.address      = base + {{8{r.acc_b[7]}}, r.acc_b};
                        res.extra_cycles = 4'd1;
                    end
                    ipag_pkg::MODE_ACC_A,
                    ipag_pkg::MODE_ACC_A | ipag_pkg::MODE_IND: begin
                        res.address      = base + {{8{r.acc_a[7]}}, r.acc_a};
                        res.extra_cycles = 4'd1;
                    end
                    ipag_pkg::MODE_OFF8,
                    ipag_pkg::MODE_OFF8 | ipag_pkg::MODE_IND: begin
                        res.address      = base + {{8{r.offset_first[7]}}, r.offset_first};
                        res.offset_bytes = 2'd1;
                        res.extra_cycles = 4'd1;
                    end
                    ipag_pkg::MODE_OFF16,
                    ipag_pkg::MODE_OFF16 | ipag_pkg::MODE_IND: begin
                        res.address      = base + word;
                        res.offset_bytes = 2'd2;
                        res.extra_cycles = 4'd4;
                    end
                    ipag_pkg::MODE_ACC_D,
                    ipag_pkg::MODE_ACC_D | ipag_pkg::MODE_IND: begin
                        res.address      = base + {r.acc_a, r.acc_b};
                        res.extra_cycles = 4'd4;
                    end
                    // PC-relative forms count from the PC after the offset bytes.
                    ipag_pkg::MODE_PCR8,
                    ipag_pkg::MODE_PCR8 | ipag_pkg::MODE_IND: begin
                        res.offset_bytes = 2'd1;
                        res.address      = r.pc_after_post + 16'd1
                                           + {{8{r.offset_first[7]}}, r.offset_first};
                        res.extra_cycles = 4'd1;
                    end
                    ipag_pkg::MODE_PCR16,
                    ipag_pkg::MODE_PCR16 | ipag_pkg::MODE_IND: begin
                        res.offset_bytes = 2'd2;
                        res.address      = r.pc_after_post + 16'd2 + word;
                        res.extra_cycles = 4'd5;
                    end
                    ipag_pkg::MODE_EXT_IND: begin
                        res.address      = word;
                        res.offset_bytes = 2'd2;
                        res.extra_cycles = 4'd2;
                    end
                    default: bad = 1'b1;
                endcase
                if (bad) begin
                    res              = '0;
                    res.bad_postbyte = 1'b1;
                end else if (res.indirect) begin
                    res.extra_cycles = res.extra_cycles + ipag_pkg::IND_CYCLES;
                end
            end
            res.reg_select = res.reg_write ? sel : ipag_pkg::REG_X;
            return res;
        endfunction

        function void note_request(ipag_pkg::t_req r);
            expected_ea_q.push_back(compute_effective_address(r));
        endfunction

        // Print one line for a differing field and count it.
        task report_mismatch(string field, logic [15:0] got, logic [15:0] want);
            if (got !== want) begin
                errors++;
                $display("mismatch on %s at result %0d: got %h, want %h",
                         field, checked, got, want);
            end
        endtask

        task check_result(ipag_pkg::t_rsp got);
            ipag_pkg::t_rsp want;
            if (expected_ea_q.size() == 0) begin
                errors++;
                $display("unexpected result %h with no request outstanding", got);
            end else begin
                want = expected_ea_q.pop_front();
                report_mismatch("address", got.address, want.address);
                report_mismatch("indirect", got.indirect, want.indirect);
                report_mismatch("reg_write", got.reg_write, want.reg_write);
                report_mismatch("reg_select", got.reg_select, want.reg_select);
                report_mismatch("reg_value", got.reg_value, want.reg_value);
                report_mismatch("offset_bytes", got.offset_bytes, want.offset_bytes);
                report_mismatch("extra_cycles", got.extra_cycles, want.extra_cycles);
                report_mismatch("bad_postbyte", got.bad_postbyte, want.bad_postbyte);
                bad_seen       += want.bad_postbyte;
                writeback_seen += want.reg_write;
                indirect_seen  += want.indirect;
                checked++;
            end
        endtask
    endclass

    logic           i_clk   = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           calm    = 1'b0;    // when set, neither side idles
    int unsigned    cycle_count = 0;
    int unsigned    sent_count  = 0;
    t_ea_scoreboard sb;

    ipag_chan_if #(.T(ipag_pkg::t_req)) req_if ();
    ipag_chan_if #(.T(ipag_pkg::t_rsp)) rsp_if ();

    indexed_postbyte_address_gen dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs or loses results.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.expected_ea_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Both channels are sampled at the rising edge, before the block's own
    // updates land, so every handshake is seen exactly as the block saw it.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                sb.note_request(req_if.data);
            end
            if (rsp_if.valid && rsp_if.ready) begin
                sb.check_result(rsp_if.data);
            end
        end
    end

    // The result side stalls about a third of the cycles, except in the calm stretch.
    always @(negedge i_clk) begin
        rsp_if.ready = calm || ($urandom_range(0, 99) >= 33);
    end

    // Corner values show up often so that every add wraps at both ends.
    function logic [15:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h7FFF;
            3:       return 16'h8000;
            4:       return 16'hFFFE;
            default: return 16'($urandom);
        endcase
    endfunction

    function logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            2:       return 8'h7F;
            3:       return 8'h80;
            default: return 8'($urandom);
        endcase
    endfunction

    // Present one item from a falling edge and hold it until the block takes it.
    // Random idle cycles come first, with valid low.
    task send_request(ipag_pkg::t_req r);
        while (!calm && $urandom_range(0, 99) < 33) begin
            req_if.valid = 1'b0;
            @(negedge i_clk);
        end
        req_if.valid = 1'b1;
        req_if.data  = r;
        do begin
            @(posedge i_clk);
        end while (!req_if.ready);
        sent_count++;
        @(negedge i_clk);
    endtask

    initial begin
        ipag_pkg::t_req req;
        logic [15:0]    fill;
        sb            = new();
        req_if.valid  = 1'b0;
        req_if.data   = '0;
        rsp_if.ready  = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed items: alternate all-ones and all-zeros fills, with a bit flipped in some operands,
        // so that the auto increment, decrement and offset sums wrap in both directions.
        foreach (DIRECTED_PB[i]) begin
            fill              = (i % 2 == 0) ? 16'hFFFF : 16'h0000;
            req.postbyte      = DIRECTED_PB[i];
            req.offset_first  = fill[7:0] ^ 8'h80;
            req.offset_second = fill[7:0];
            req.reg_x         = fill;
            req.reg_y         = fill ^ 16'h8000;
            req.reg_u         = fill;
            req.reg_s         = fill ^ 16'h0001;
            req.acc_a         = fill[7:0];
            req.acc_b         = fill[7:0] ^ 8'h80;
            req.pc_after_post = fill;
            send_request(req);
        end

        // Random items: every postbyte value is reachable, so all forms and the
        // undefined ones appear; a stretch in the middle runs at full rate.
        for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
            calm              = (n >= 700 && n < 1000);
            req.postbyte      = 8'($urandom);
            req.offset_first  = pick_byte();
            req.offset_second = pick_byte();
            req.reg_x         = pick_word();
            req.reg_y         = pick_word();
            req.reg_u         = pick_word();
            req.reg_s         = pick_word();
            req.acc_a         = pick_byte();
            req.acc_b         = pick_byte();
            req.pc_after_post = pick_word();
            send_request(req);
        end
        calm         = 1'b0;
        req_if.valid = 1'b0;

        // Drain, then give the pipeline time to show any stray result.
        while (sb.expected_ea_q.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (PIPE_DEPTH + 5) @(negedge i_clk);

        $display("covered %0d items and %0d results: %0d undefined postbytes,",
                 sent_count, sb.checked, sb.bad_seen);
        $display("  %0d register write-backs, %0d indirect forms, %0d mismatches",
                 sb.writeback_seen, sb.indirect_seen, sb.errors);
        if (sb.errors == 0 && sb.expected_ea_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/ipag_pkg.sv
rtl/core/ipag_chan_if.sv
rtl/core/indexed_postbyte_address_gen.sv
rtl/core/ipag_checker.sv
dv/tb.sv
